// ===== design/ictc_pkg.sv =====
package ictc_pkg;

	// byte positions within the IPv4 header
	localparam logic [15:0] POS_IHL       = 16'd0;
	localparam logic [15:0] POS_LEN_HI    = 16'd2;
	localparam logic [15:0] POS_LEN_LO    = 16'd3;
	localparam logic [15:0] POS_HDR_MIN   = 16'd4;   // bytes always taken in
	localparam logic [15:0] POS_PROTO     = 16'd9;
	localparam logic [15:0] POS_IP_CSUM   = 16'd10;
	localparam logic [15:0] POS_IP_CSUM_L = 16'd11;
	localparam logic [15:0] POS_ADDR_ODD0 = 16'd13;  // first odd address byte
	localparam logic [15:0] POS_ADDR_END  = 16'd19;
	localparam logic [15:0] SEG_CSUM_OFS  = 16'd16;  // TCP checksum offset in segment
	localparam logic [15:0] IDX_SAT       = 16'hFFFF;
	localparam logic [3:0]  IHL_MIN       = 4'd5;

	// request queue between front and back
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);

	typedef enum logic [1:0] {
		ST_COMPLETE = 2'd0,
		ST_SHORT    = 2'd1,
		ST_BAD_IHL  = 2'd2
	} status_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last;
	} in_item_t;

	typedef struct packed {
		logic [15:0] ip_sum_value;
		logic [15:0] tcp_sum_value;
		logic        ip_ok;
		logic        tcp_ok;
		logic [1:0]  status;
	} out_item_t;

	// one classified byte, as queued for the back end
	typedef struct packed {
		logic [15:0] word;       // completed 16-bit word
		logic        word_ip;
		logic        word_seg;
		logic [15:0] pad_word;   // odd trailing byte, padded low
		logic        pad_ip;
		logic        pad_seg;
		logic [15:0] pseudo;     // pseudo-header term, zero if none
		logic [15:0] len_word;   // TCP length, zero unless last
		logic [7:0]  data_byte;
		logic        rx_ip_hi;
		logic        rx_ip_lo;
		logic        rx_seg_hi;
		logic        rx_seg_lo;
		logic        last;
		logic [1:0]  status;
	} cmd_t;

endpackage

// ===== design/ipv4_tcp_checksum_check_unit.sv =====
// Throughput: one packet byte per cycle while the request queue is not full, with no gap between packets.
// After the edge that takes the last byte, the result passes the queue write, the term fold
// into the back stage register, then the accumulate into the result register.
// Stalls on the result side back up through a four-entry request queue.
// Reset (arst_n low, asynchronous): counters, sums, queue and valid flags clear.
module ipv4_tcp_checksum_check_unit import ictc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      byte_valid,
	output logic      byte_ready,
	input  in_item_t  byte_data,
	output logic      res_valid,
	input  logic      res_ready,
	output out_item_t res_data
);

	// front: tracks byte index, IHL, total length and the pending even byte,
	// and turns each byte into a request of ready-made checksum terms
	logic q_push, q_full, q_pop, q_empty;
	cmd_t q_wr, q_rd;

	ictc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_ready (byte_ready),
		.byte_data  (byte_data),
		.push       (q_push),
		.cmd        (q_wr),
		.full       (q_full)
	);

	// queue decouples byte intake from result delivery
	ictc_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.wr_entry (q_wr),
		.full     (q_full),
		.pop      (q_pop),
		.empty    (q_empty),
		.rd_entry (q_rd)
	);

	// back: folds each request's terms, adds them into the ones-complement
	// sums, keeps the received checksums and builds the result on the last byte
	ictc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_entry   (q_rd),
		.q_pop     (q_pop),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_data  (res_data)
	);

`ifndef SYNTHESIS
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("request queue popped while empty");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("request queue written while full");

	a_take_when_accepted: assert property (@(posedge clk) disable iff (!arst_n)
		(byte_valid && byte_ready) |-> q_push)
		else $error("accepted byte not queued");
`endif

endmodule

// ===== design/ictc_front.sv =====
module ictc_front import ictc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     byte_valid,
	output logic     byte_ready,
	input  in_item_t byte_data,
	output logic     push,
	output cmd_t     cmd,
	input  logic     full
);

	logic [15:0] idx_q, len_q;
	logic [3:0]  hdr_q;
	logic [7:0]  high_q;

	logic [15:0] idx_n, len_n, hb16, chk_pos, pos, cnt_n, counted, pad_pos;
	logic [7:0]  b, high_n;
	logic [3:0]  hdr_n;
	logic        proc, odd, cnt_in, pad;

	assign byte_ready = !full;
	assign push       = byte_valid && !full;

	always_comb begin
		b      = byte_data.data_byte;
		proc   = (idx_q < POS_HDR_MIN) || (idx_q < len_q);
		hdr_n  = (proc && idx_q == POS_IHL) ? b[3:0] : hdr_q;
		len_n  = len_q;
		if (proc && idx_q == POS_LEN_HI) begin
			len_n = {b, 8'h00};
		end
		if (proc && idx_q == POS_LEN_LO) begin
			len_n = {len_q[15:8], b};
		end
		hb16    = {10'd0, hdr_n, 2'b00};
		chk_pos = hb16 + SEG_CSUM_OFS;
		high_n  = (proc && !idx_q[0]) ? b : high_q;
		odd     = proc && idx_q[0];
		pos     = idx_q - 16'd1;

		cmd.word     = {high_q, b};
		cmd.word_ip  = odd && (pos < hb16) && (pos != POS_IP_CSUM);
		cmd.word_seg = odd && !(pos < hb16) && (pos != chk_pos);

		// protocol byte, then source and destination address words
		cmd.pseudo = 16'h0000;
		if (proc && idx_q == POS_PROTO) begin
			cmd.pseudo = {8'h00, b};
		end else if (odd && idx_q >= POS_ADDR_ODD0 && idx_q <= POS_ADDR_END) begin
			cmd.pseudo = {high_q, b};
		end

		idx_n   = (idx_q == IDX_SAT) ? idx_q : idx_q + 16'd1;
		cnt_n   = idx_n;
		cnt_in  = (cnt_n < POS_HDR_MIN) || (cnt_n < len_n);
		counted = cnt_in ? cnt_n : len_n;
		pad     = byte_data.last && counted[0];
		pad_pos = counted - 16'd1;

		cmd.pad_word = {high_n, 8'h00};
		cmd.pad_ip   = pad && (pad_pos < hb16) && (pad_pos != POS_IP_CSUM);
		cmd.pad_seg  = pad && !(pad_pos < hb16) && (pad_pos != chk_pos);
		cmd.len_word = byte_data.last ? (len_n - hb16) : 16'h0000;

		cmd.data_byte = b;
		cmd.rx_ip_hi  = proc && idx_q == POS_IP_CSUM;
		cmd.rx_ip_lo  = proc && idx_q == POS_IP_CSUM_L;
		cmd.rx_seg_hi = proc && idx_q == chk_pos;
		cmd.rx_seg_lo = proc && idx_q == 16'(chk_pos + 16'd1);
		cmd.last      = byte_data.last;

		if (hdr_n < IHL_MIN) begin
			cmd.status = ST_BAD_IHL;
		end else if (cnt_in) begin
			cmd.status = ST_SHORT;
		end else begin
			cmd.status = ST_COMPLETE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= '0;
			hdr_q  <= '0;
			len_q  <= '0;
			high_q <= '0;
		end else if (push) begin
			if (byte_data.last) begin
				idx_q  <= '0;
				hdr_q  <= '0;
				len_q  <= '0;
				high_q <= '0;
			end else begin
				idx_q  <= idx_n;
				hdr_q  <= hdr_n;
				len_q  <= len_n;
				high_q <= high_n;
			end
		end
	end

endmodule

// ===== design/ictc_fifo.sv =====
module ictc_fifo import ictc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t wr_entry,
	output logic full,
	input  logic pop,
	output logic empty,
	output cmd_t rd_entry
);

	cmd_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QPTR_W:0]   cnt_q;

	assign full     = (cnt_q == (QPTR_W+1)'(QDEPTH));
	assign empty    = (cnt_q == '0);
	assign rd_entry = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== design/ictc_back.sv =====
module ictc_back import ictc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      q_empty,
	input  cmd_t      q_entry,
	output logic      q_pop,
	output logic      res_valid,
	input  logic      res_ready,
	output out_item_t res_data
);

	typedef struct packed {
		logic [15:0] ip_term;
		logic [15:0] seg_term;
		logic [7:0]  data_byte;
		logic        rx_ip_hi;
		logic        rx_ip_lo;
		logic        rx_seg_hi;
		logic        rx_seg_lo;
		logic        last;
		logic [1:0]  status;
	} term_t;

	// end-around carry sums; a zero term leaves the sum unchanged
	function automatic logic [15:0] oc_add2(input logic [15:0] a, input logic [15:0] c);
		logic [16:0] s;
		s = {1'b0, a} + {1'b0, c};
		return s[15:0] + {15'd0, s[16]};
	endfunction

	function automatic logic [15:0] oc_add4(input logic [15:0] a, input logic [15:0] c,
			input logic [15:0] d, input logic [15:0] e);
		logic [17:0] s;
		logic [16:0] f;
		s = {2'b00, a} + {2'b00, c} + {2'b00, d} + {2'b00, e};
		f = {1'b0, s[15:0]} + {15'd0, s[17:16]};
		return f[15:0] + {15'd0, f[16]};
	endfunction

	term_t       b1_s1, b1_nx;
	logic        b1_valid_q, b1_go;
	logic [15:0] ip_acc_q, seg_acc_q, rx_ip_q, rx_seg_q;
	logic [15:0] ip_nx, seg_nx, rx_ip_nx, rx_seg_nx, ip_sum, tcp_sum;
	logic        res_valid_q;
	out_item_t   res_q;

	assign b1_go     = b1_valid_q && !(b1_s1.last && res_valid_q && !res_ready);
	assign q_pop     = !q_empty && (!b1_valid_q || b1_go);
	assign res_valid = res_valid_q;
	assign res_data  = res_q;

	always_comb begin
		b1_nx.ip_term  = oc_add2(q_entry.word_ip ? q_entry.word : 16'h0000,
			q_entry.pad_ip ? q_entry.pad_word : 16'h0000);
		b1_nx.seg_term = oc_add4(q_entry.pseudo,
			q_entry.word_seg ? q_entry.word : 16'h0000,
			q_entry.pad_seg ? q_entry.pad_word : 16'h0000,
			q_entry.len_word);
		b1_nx.data_byte = q_entry.data_byte;
		b1_nx.rx_ip_hi  = q_entry.rx_ip_hi;
		b1_nx.rx_ip_lo  = q_entry.rx_ip_lo;
		b1_nx.rx_seg_hi = q_entry.rx_seg_hi;
		b1_nx.rx_seg_lo = q_entry.rx_seg_lo;
		b1_nx.last      = q_entry.last;
		b1_nx.status    = q_entry.status;
	end

	always_comb begin
		ip_nx     = oc_add2(ip_acc_q, b1_s1.ip_term);
		seg_nx    = oc_add2(seg_acc_q, b1_s1.seg_term);
		rx_ip_nx  = rx_ip_q;
		rx_seg_nx = rx_seg_q;
		if (b1_s1.rx_ip_hi) begin
			rx_ip_nx = {b1_s1.data_byte, rx_ip_q[7:0]};
		end
		if (b1_s1.rx_ip_lo) begin
			rx_ip_nx = {rx_ip_q[15:8], b1_s1.data_byte};
		end
		if (b1_s1.rx_seg_hi) begin
			rx_seg_nx = {b1_s1.data_byte, rx_seg_q[7:0]};
		end
		if (b1_s1.rx_seg_lo) begin
			rx_seg_nx = {rx_seg_q[15:8], b1_s1.data_byte};
		end
		ip_sum  = ~ip_nx;
		tcp_sum = ~seg_nx;
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			b1_s1 <= b1_nx;
		end
		if (b1_go && b1_s1.last) begin
			res_q.ip_sum_value  <= ip_sum;
			res_q.tcp_sum_value <= tcp_sum;
			res_q.ip_ok         <= (ip_sum == rx_ip_nx);
			res_q.tcp_ok        <= (tcp_sum == rx_seg_nx);
			res_q.status        <= b1_s1.status;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b1_valid_q  <= 1'b0;
			res_valid_q <= 1'b0;
			ip_acc_q    <= '0;
			seg_acc_q   <= '0;
			rx_ip_q     <= '0;
			rx_seg_q    <= '0;
		end else begin
			if (q_pop) begin
				b1_valid_q <= 1'b1;
			end else if (b1_go) begin
				b1_valid_q <= 1'b0;
			end
			if (b1_go && b1_s1.last) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
			if (b1_go) begin
				if (b1_s1.last) begin
					ip_acc_q  <= '0;
					seg_acc_q <= '0;
					rx_ip_q   <= '0;
					rx_seg_q  <= '0;
				end else begin
					ip_acc_q  <= ip_nx;
					seg_acc_q <= seg_nx;
					rx_ip_q   <= rx_ip_nx;
					rx_seg_q  <= rx_seg_nx;
				end
			end
		end
	end

endmodule
